@@ src/lcf_pkg.sv @@
`default_nettype none

package lcf_pkg;

    localparam logic [7:0] HUE_REGION = 8'd43;
    localparam logic [7:0] HUE_STEPS  = 8'd6;
    localparam logic [7:0] FULL       = 8'd255;

    // register indexes on the config channel
    localparam logic CFG_GRB_ORDER = 1'b0;
    localparam logic CFG_LEVEL     = 1'b1;

    // three bytes of a packed color, top byte first
    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
    } color_t;

endpackage

`default_nettype wire

@@ src/led_color_formatter.sv @@
// LED color formatter.
// Input channel (in_valid/in_ready): one color request per beat, RGB or HSV
// per func, with optional square-law gamma on RGB values.
// Output channel (out_valid/out_ready): packed_color in RGB or GRB order and
// scaled_color, the same bytes scaled by level/255.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// grb_order from cfg_data[0], index 1 writes level. Write only while idle.
// Throughput: one beat per cycle unless the output stalls; five register
// stages (hue split and gamma/p product, saturation products, q/t products
// and packing, level products, divide by 255 and output register).
// Stall: while out_valid is high and out_ready low the whole pipe holds and
// in_ready is low; nothing is dropped or repeated.
// Reset: all stage valids clear, grb_order = 1, level = 255.
`default_nettype none

module led_color_formatter
    import lcf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  first_value,
    input  wire logic [7:0]  second_value,
    input  wire logic [7:0]  third_value,
    input  wire logic        apply_gamma,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      packed_color,
    output logic [23:0]      scaled_color,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        HUE_R_TO_Y = 3'd0,
        HUE_Y_TO_G = 3'd1,
        HUE_G_TO_C = 3'd2,
        HUE_C_TO_B = 3'd3,
        HUE_B_TO_M = 3'd4,
        HUE_M_TO_R = 3'd5
    } hue_region_t;

    function automatic logic [7:0] gamma_sq(input logic [7:0] c);
        logic [16:0] cp;
        logic [16:0] sq;
        begin
            cp = {9'b0, c} + 17'd1;
            sq = cp * cp - 17'd1;
            return sq[15:8];
        end
    endfunction

    logic advance;
    logic sc_valid;

    // ---------------- configuration ----------------
    logic       grb_order_reg;
    logic [7:0] level_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grb_order_reg <= 1'b1;
            level_reg     <= FULL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRB_ORDER: grb_order_reg <= cfg_data[0];
                CFG_LEVEL:     level_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign advance  = !sc_valid || out_ready;
    assign in_ready = advance;

    // ---------------- stage 1: hue split, gamma, p product ----------------
    hue_region_t s1_region_next;
    logic [7:0]  s1_base;
    logic [7:0]  s1_diff;
    logic [7:0]  s1_rem_next;

    always_comb
    begin
        if (first_value < HUE_REGION)
        begin
            s1_region_next = HUE_R_TO_Y;
            s1_base        = 8'd0;
        end
        else if (first_value < 8'(2 * HUE_REGION))
        begin
            s1_region_next = HUE_Y_TO_G;
            s1_base        = HUE_REGION;
        end
        else if (first_value < 8'(3 * HUE_REGION))
        begin
            s1_region_next = HUE_G_TO_C;
            s1_base        = 8'(2 * HUE_REGION);
        end
        else if (first_value < 8'(4 * HUE_REGION))
        begin
            s1_region_next = HUE_C_TO_B;
            s1_base        = 8'(3 * HUE_REGION);
        end
        else if (first_value < 8'(5 * HUE_REGION))
        begin
            s1_region_next = HUE_B_TO_M;
            s1_base        = 8'(4 * HUE_REGION);
        end
        else
        begin
            s1_region_next = HUE_M_TO_R;
            s1_base        = 8'(5 * HUE_REGION);
        end
        s1_diff     = first_value - s1_base;
        s1_rem_next = s1_diff * HUE_STEPS;
    end

    logic        s1_valid_reg;
    logic        s1_hsv_reg;
    hue_region_t s1_region_reg;
    logic [7:0]  s1_rem_reg;
    logic [7:0]  s1_sat_reg;
    logic [7:0]  s1_val_reg;
    logic [15:0] s1_pprod_reg;
    logic [7:0]  s1_r_reg;
    logic [7:0]  s1_g_reg;
    logic [7:0]  s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_hsv_reg    <= func;
            s1_region_reg <= s1_region_next;
            s1_rem_reg    <= s1_rem_next;
            s1_sat_reg    <= second_value;
            s1_val_reg    <= third_value;
            s1_pprod_reg  <= {8'b0, third_value} * {8'b0, FULL - second_value};
            if (apply_gamma)
            begin
                s1_r_reg <= gamma_sq(first_value);
                s1_g_reg <= gamma_sq(second_value);
                s1_b_reg <= gamma_sq(third_value);
            end
            else
            begin
                s1_r_reg <= first_value;
                s1_g_reg <= second_value;
                s1_b_reg <= third_value;
            end
        end
    end

    // ---------------- stage 2: saturation products ----------------
    logic [15:0] s2_sr_prod;
    logic [15:0] s2_srn_prod;

    assign s2_sr_prod  = {8'b0, s1_sat_reg} * {8'b0, s1_rem_reg};
    assign s2_srn_prod = {8'b0, s1_sat_reg} * {8'b0, FULL - s1_rem_reg};

    logic        s2_valid_reg;
    logic        s2_hsv_reg;
    logic        s2_grey_reg;
    hue_region_t s2_region_reg;
    logic [7:0]  s2_val_reg;
    logic [7:0]  s2_p_reg;
    logic [7:0]  s2_qf_reg;
    logic [7:0]  s2_tf_reg;
    logic [7:0]  s2_r_reg;
    logic [7:0]  s2_g_reg;
    logic [7:0]  s2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_hsv_reg    <= s1_hsv_reg;
            s2_grey_reg   <= (s1_sat_reg == 8'd0);
            s2_region_reg <= s1_region_reg;
            s2_val_reg    <= s1_val_reg;
            s2_p_reg      <= s1_pprod_reg[15:8];
            s2_qf_reg     <= FULL - s2_sr_prod[15:8];
            s2_tf_reg     <= FULL - s2_srn_prod[15:8];
            s2_r_reg      <= s1_r_reg;
            s2_g_reg      <= s1_g_reg;
            s2_b_reg      <= s1_b_reg;
        end
    end

    // ---------------- stage 3: q/t products, region select, pack ----------------
    logic [15:0] s3_qprod;
    logic [15:0] s3_tprod;
    logic [7:0]  s3_q;
    logic [7:0]  s3_t;
    logic [7:0]  s3_r;
    logic [7:0]  s3_g;
    logic [7:0]  s3_b;
    color_t      s3_color_next;

    assign s3_qprod = {8'b0, s2_val_reg} * {8'b0, s2_qf_reg};
    assign s3_tprod = {8'b0, s2_val_reg} * {8'b0, s2_tf_reg};
    assign s3_q     = s3_qprod[15:8];
    assign s3_t     = s3_tprod[15:8];

    always_comb
    begin
        s3_r = s2_r_reg;
        s3_g = s2_g_reg;
        s3_b = s2_b_reg;
        if (s2_hsv_reg)
        begin
            case (s2_region_reg)
                HUE_R_TO_Y: begin s3_r = s2_val_reg; s3_g = s3_t;       s3_b = s2_p_reg;   end
                HUE_Y_TO_G: begin s3_r = s3_q;       s3_g = s2_val_reg; s3_b = s2_p_reg;   end
                HUE_G_TO_C: begin s3_r = s2_p_reg;   s3_g = s2_val_reg; s3_b = s3_t;       end
                HUE_C_TO_B: begin s3_r = s2_p_reg;   s3_g = s3_q;       s3_b = s2_val_reg; end
                HUE_B_TO_M: begin s3_r = s3_t;       s3_g = s2_p_reg;   s3_b = s2_val_reg; end
                default:    begin s3_r = s2_val_reg; s3_g = s2_p_reg;   s3_b = s3_q;       end
            endcase
            // zero saturation: grey, same in either channel order
            if (s2_grey_reg)
            begin
                s3_r = s2_val_reg;
                s3_g = s2_val_reg;
                s3_b = s2_val_reg;
            end
        end
        s3_color_next.hi  = grb_order_reg ? s3_g : s3_r;
        s3_color_next.mid = grb_order_reg ? s3_r : s3_g;
        s3_color_next.lo  = s3_b;
    end

    logic   s3_valid_reg;
    color_t s3_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s3_color_reg <= s3_color_next;
    end

    // ---------------- stages 4 and 5: brightness scaling ----------------
    color_t sc_packed;
    color_t sc_scaled;

    lcf_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (s3_valid_reg),
        .in_color   (s3_color_reg),
        .level      (level_reg),
        .out_valid  (sc_valid),
        .out_packed (sc_packed),
        .out_scaled (sc_scaled)
    );

    assign out_valid    = sc_valid;
    assign packed_color = sc_packed;
    assign scaled_color = sc_scaled;

endmodule

`default_nettype wire

@@ src/lcf_scale.sv @@
`default_nettype none

module lcf_scale
    import lcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire color_t     in_color,
    input  wire logic [7:0] level,
    output logic            out_valid,
    output color_t          out_packed,
    output color_t          out_scaled
);

    // floor(x / 255), exact for any 16-bit x whose quotient fits in 8 bits
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
            return sum[15:8];
        end
    endfunction

    logic        prod_valid_reg;
    color_t      prod_color_reg;
    logic [15:0] prod_hi_reg;
    logic [15:0] prod_mid_reg;
    logic [15:0] prod_lo_reg;

    logic        out_valid_reg;
    color_t      out_packed_reg;
    color_t      out_scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_color_reg     <= in_color;
            prod_hi_reg        <= {8'b0, in_color.hi}  * {8'b0, level};
            prod_mid_reg       <= {8'b0, in_color.mid} * {8'b0, level};
            prod_lo_reg        <= {8'b0, in_color.lo}  * {8'b0, level};
            out_packed_reg     <= prod_color_reg;
            out_scaled_reg.hi  <= div255(prod_hi_reg);
            out_scaled_reg.mid <= div255(prod_mid_reg);
            out_scaled_reg.lo  <= div255(prod_lo_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_packed = out_packed_reg;
    assign out_scaled = out_scaled_reg;

endmodule

`default_nettype wire

@@ src/lcf_checker.sv @@
`default_nettype none

module lcf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] packed_color,
    input wire logic [23:0] scaled_color
);

    // the packed_color of a held result beat must not change under stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(packed_color)))
        else $error("output beat changed while stalled");

    // a stalled output freezes the whole pipe
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

    // an empty or draining output never blocks the input side
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked with free output");

    // brightness never raises a byte
    a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scaled_color[23:16] <= packed_color[23:16]) &&
                      (scaled_color[15:8]  <= packed_color[15:8])  &&
                      (scaled_color[7:0]   <= packed_color[7:0]))
        else $error("scaled byte above packed byte");

endmodule

bind led_color_formatter lcf_checker u_lcf_checker (.*);

`default_nettype wire
